>>> hdl/mpsg_pkg.sv
// Shared types and constants of the minimum path sum block.
package mpsg_pkg;

	localparam int VALUE_W = 32;
	localparam int SUM_W = 48;
	localparam int SIDE_W = 9;
	localparam int SIDE_RESET = 16;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [SIDE_W-1:0] side_t;

	// Control that every cell of the row store receives each cycle.
	typedef struct packed {
		logic advance;
		logic load;
	} cell_ctrl_t;

endpackage

>>> hdl/mpsg_in_if.sv
// Input channel: one grid cell value per word.
interface mpsg_in_if
	import mpsg_pkg::*;
;
	logic valid;
	logic ready;
	value_t cell_value;

	modport source (output valid, output cell_value, input ready);
	modport sink (input valid, input cell_value, output ready);
endinterface

>>> hdl/mpsg_out_if.sv
// Output channel: one path sum and end-of-grid flag per word.
interface mpsg_out_if
	import mpsg_pkg::*;
;
	logic valid;
	logic ready;
	sum_t path_sum;
	logic grid_done;

	modport source (output valid, output path_sum, output grid_done, input ready);
	modport sink (input valid, input path_sum, input grid_done, output ready);
endinterface

>>> hdl/min_path_sum_grid_dp_top.sv
// A result word is registered and valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while the output is not stalled; the left/up select and add are combinational.
// The previous row's sums travel through a chain of MAX_SIDE cells, entering at
// position MAX_SIDE - side so that each returns exactly one row later.
// Reset clears the grid position, the left sum and the output valid, and sets
// the side to 16; the chain needs no clearing since row 0 never reads it.
module min_path_sum_grid_dp_top
	import mpsg_pkg::*;
#(
	parameter int MAX_SIDE = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  side_t      cfg_wdata,
	mpsg_in_if.sink    item,
	mpsg_out_if.source result
);

	localparam int IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

	typedef logic [IDX_W-1:0] idx_t;

	// Last row/column index for a written side, with zero acting as one and
	// oversized sides limited to MAX_SIDE.
	function automatic idx_t last_of(input side_t s);
		int v;
		v = int'(s);
		if (v == 0) v = 1;
		if (v > MAX_SIDE) v = MAX_SIDE;
		return IDX_W'(v - 1);
	endfunction

	localparam idx_t LAST_RESET = last_of(side_t'(SIDE_RESET));
	localparam idx_t INS_RESET = IDX_W'(MAX_SIDE - 1 - int'(LAST_RESET));

	idx_t last_q;
	idx_t ins_q;
	idx_t row_q;
	idx_t col_q;
	sum_t left_q;

	logic out_valid_q;
	sum_t path_sum_q;
	logic grid_done_q;

	logic accept;
	logic ready;
	sum_t value_ext;
	sum_t up_sum;
	sum_t addend;
	sum_t new_sum;
	logic done;

	sum_t chain [MAX_SIDE];

	// The input may enter whenever the output register is empty or draining.
	assign ready = !out_valid_q || result.ready;
	assign accept = item.valid && ready;
	assign item.ready = ready;

	// Row store: a chain of cells, the oldest sum leaving at the far end.
	for (genvar i = 0; i < MAX_SIDE; i++) begin : g_cells
		cell_ctrl_t ctrl;
		sum_t prev;

		assign ctrl.advance = accept;
		assign ctrl.load = (ins_q == IDX_W'(i));
		if (i == 0) begin : g_head
			assign prev = new_sum;
		end else begin : g_body
			assign prev = chain[i-1];
		end

		mpsg_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.new_sum  (new_sum),
			.prev_sum (prev),
			.sum      (chain[i])
		);
	end

	assign up_sum = chain[MAX_SIDE-1];

	// Pick the cheaper neighbour (a tie takes the upper one) and add the cell.
	always_comb begin
		value_ext = SUM_W'(item.cell_value);
		if (row_q == '0 && col_q == '0) begin
			addend = '0;
		end else if (row_q == '0) begin
			addend = left_q;
		end else if (col_q == '0) begin
			addend = up_sum;
		end else if (left_q < up_sum) begin
			addend = left_q;
		end else begin
			addend = up_sum;
		end
		new_sum = value_ext + addend;
		done = (row_q == last_q) && (col_q == last_q);
	end

	// Grid position, side and left sum; a side write restarts the grid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= LAST_RESET;
			ins_q <= INS_RESET;
			row_q <= '0;
			col_q <= '0;
			left_q <= '0;
		end else if (cfg_we) begin
			last_q <= last_of(cfg_wdata);
			ins_q <= IDX_W'(MAX_SIDE - 1 - int'(last_of(cfg_wdata)));
			row_q <= '0;
			col_q <= '0;
			left_q <= '0;
		end else if (accept) begin
			left_q <= new_sum;
			if (col_q == last_q) begin
				col_q <= '0;
				row_q <= (row_q == last_q) ? '0 : row_q + IDX_W'(1);
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			path_sum_q <= new_sum;
			grid_done_q <= done;
		end
	end

	assign result.valid = out_valid_q;
	assign result.path_sum = path_sum_q;
	assign result.grid_done = grid_done_q;

endmodule

>>> hdl/mpsg_cell.sv
// One cell of the row store: holds a single column sum of the previous row.
module mpsg_cell
	import mpsg_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  sum_t       new_sum,
	input  sum_t       prev_sum,
	output sum_t       sum
);

	sum_t sum_q;

	// On each accepted word the cell either takes the fresh sum (at the
	// insertion point) or the value of its upstream neighbour.
	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			sum_q <= ctrl.load ? new_sum : prev_sum;
		end
	end

	assign sum = sum_q;

endmodule
